// ----- src/ray_rect_edge_nearest_hit_assert.svh -----
// ============================================================================
// Ray/rectangle edge hit - assertion macros
// Shared concurrent assertion forms, synchronous active-low reset.
// ============================================================================
`ifndef RAY_RECT_EDGE_NEAREST_HIT_ASSERT_SVH
`define RAY_RECT_EDGE_NEAREST_HIT_ASSERT_SVH

// condition must never hold outside reset
`define RREH_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("rreh: forbidden condition seen");

// antecedent in one cycle forces consequent in the next
`define RREH_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rreh: expected follow-up missing");

`endif

// ----- src/rreh_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rreh_pkg
// Widths, payload types, unit status and state encoding for the ray/rectangle
// edge nearest-hit block.
// ============================================================================
package rreh_pkg;

    // coordinate width (signed Q16.16 by default)
    localparam int CW    = 32;
    localparam int DW    = CW + 1;                    // coordinate difference
    localparam int FRAC  = 16;
    localparam int NPW   = 32;                        // nearest parameter width
    localparam int MW    = (CW > NPW) ? CW : NPW;     // multiplier magnitude
    localparam int MOW   = MW + 1;                    // signed mult operand
    localparam int PW    = 2 * MW;                    // product magnitude
    localparam int SPW   = PW + 1;                    // signed product
    localparam int NW    = PW + 2;                    // sum of two products
    localparam int DVW   = CW + FRAC;                 // dividend / quotient
    localparam int PARAM_LIMIT = 9000;

    localparam logic [NPW-1:0] SENT = NPW'(PARAM_LIMIT * (2 ** FRAC));

    // configuration register indexes
    localparam logic [1:0] REG_START_X = 2'd0;
    localparam logic [1:0] REG_START_Y = 2'd1;
    localparam logic [1:0] REG_STOP_X  = 2'd2;
    localparam logic [1:0] REG_STOP_Y  = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] rect_left;
        logic signed [CW-1:0] rect_right;
        logic signed [CW-1:0] rect_top;
        logic signed [CW-1:0] rect_bottom;
        logic                 last_rect;
    } t_req;

    typedef struct packed {
        logic                 hit;
        logic signed [CW-1:0] stop_x;
        logic signed [CW-1:0] stop_y;
    } t_rsp;

    // status of a serial arithmetic unit
    typedef struct packed {
        logic busy;
        logic done;
    } t_ustat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_EDGE,
        S_DIV,
        S_SMUL,
        S_EMIT
    } t_state;

endpackage

// ----- src/ray_rect_edge_nearest_hit.sv -----
`timescale 1ns / 1ps
// Per rectangle: six products through the multiplier (MW = 32 by default), then per edge
// either a rejection or a division through the divider (DVW = 48).
// A last rectangle emits a response, after two more products for the stop point on a hit.
// A new request is taken only in the idle state, so one rectangle is handled at a time,
// on the shared bit-serial multiplier and divider.
// Reset (synchronous, active low): ray registers to zero, nearest parameter to 9000.0.
// ============================================================================
// ray_rect_edge_nearest_hit
// Nearest crossing of a configured ray with the edges of a list of rectangles,
// built on a serial multiplier and a serial divider.
// ============================================================================
`include "ray_rect_edge_nearest_hit_assert.svh"

module ray_rect_edge_nearest_hit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    output logic                         o_req_ready,
    input  rreh_pkg::t_req               i_req,
    output logic                         o_rsp_valid,
    input  logic                         i_rsp_ready,
    output rreh_pkg::t_rsp               o_rsp,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_idx,
    input  logic [rreh_pkg::CW-1:0]      i_cfg_data
);
    import rreh_pkg::*;

    // product slots, in issue order
    localparam logic [2:0] M_DEN_V = 3'd0;   // (T-B)*Dx
    localparam logic [2:0] M_DEN_H = 3'd1;   // (R-L)*Dy
    localparam logic [2:0] M_A_TOP = 3'd2;   // Dx*(T-Sy)
    localparam logic [2:0] M_A_BOT = 3'd3;   // Dx*(B-Sy)
    localparam logic [2:0] M_B_LFT = 3'd4;   // Dy*(Sx-L)
    localparam logic [2:0] M_B_RGT = 3'd5;   // Dy*(Sx-R)
    localparam logic [2:0] M_STP_X = 3'd6;   // Dx*nearest
    localparam logic [2:0] M_STP_Y = 3'd7;   // Dy*nearest

    // edges
    localparam logic [1:0] E_LEFT   = 2'd0;
    localparam logic [1:0] E_RIGHT  = 2'd1;
    localparam logic [1:0] E_TOP    = 2'd2;
    localparam logic [1:0] E_BOTTOM = 2'd3;

    localparam logic signed [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic signed [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // state
    t_state                 r_state, n_state;
    logic signed [CW-1:0]   r_sx, r_sy, r_ex, r_ey;
    t_req                   r_rect;
    logic [2:0]             r_mix;
    logic [1:0]             r_eix;
    logic [NPW-1:0]         r_near, n_near;
    logic signed [SPW-1:0]  r_prod [8];
    logic                   r_out_valid;
    t_rsp                   r_rsp;

    // unit hookup
    t_ustat                 mul_st, div_st;
    logic                   mul_start, div_start;
    logic signed [MW:0]     mul_a, mul_b;
    logic signed [PW:0]     mul_prod;
    logic [CW-1:0]          div_num, div_den;
    logic [DVW-1:0]         div_quot;

    // control outputs
    logic                   accept;
    logic                   emit_load;
    logic                   edge_go;
    logic                   near_hit;
    logic                   fin_last;

    // edge evaluation
    logic signed [DW-1:0]   dx, dy;
    logic signed [SPW-1:0]  den;
    logic signed [NW-1:0]   den_x, num;
    logic signed [DW-1:0]   tn, td;
    logic                   u_ok, t_ok;
    logic                   q_better;

    // saturating stop point: floor(p / 2^FRAC) + s
    function automatic logic signed [CW-1:0] stop_sat(
        input logic signed [SPW-1:0] p,
        input logic signed [CW-1:0]  s
    );
        logic signed [SPW-1:0] sh;
        logic signed [SPW:0]   v;
        sh = p >>> FRAC;
        v  = (SPW+1)'(sh) + (SPW+1)'(s);
        if (v > (SPW+1)'(CMAX)) begin
            return CMAX;
        end else if (v < (SPW+1)'(CMIN)) begin
            return CMIN;
        end
        return CW'(v);
    endfunction

    assign dx = DW'(r_ex) - DW'(r_sx);
    assign dy = DW'(r_ey) - DW'(r_sy);

    // units
    rreh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_st    (mul_st),
        .o_prod  (mul_prod)
    );

    rreh_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_st    (div_st),
        .o_quot  (div_quot)
    );

    // multiplier operand select
    always_comb begin
        unique case (r_mix)
            M_DEN_V: begin
                mul_a = MOW'(DW'(r_rect.rect_top) - DW'(r_rect.rect_bottom));
                mul_b = MOW'(dx);
            end
            M_DEN_H: begin
                mul_a = MOW'(DW'(r_rect.rect_right) - DW'(r_rect.rect_left));
                mul_b = MOW'(dy);
            end
            M_A_TOP: begin
                mul_a = MOW'(dx);
                mul_b = MOW'(DW'(r_rect.rect_top) - DW'(r_sy));
            end
            M_A_BOT: begin
                mul_a = MOW'(dx);
                mul_b = MOW'(DW'(r_rect.rect_bottom) - DW'(r_sy));
            end
            M_B_LFT: begin
                mul_a = MOW'(dy);
                mul_b = MOW'(DW'(r_sx) - DW'(r_rect.rect_left));
            end
            M_B_RGT: begin
                mul_a = MOW'(dy);
                mul_b = MOW'(DW'(r_sx) - DW'(r_rect.rect_right));
            end
            M_STP_X: begin
                mul_a = MOW'(dx);
                mul_b = MOW'(r_near);
            end
            default: begin
                mul_a = MOW'(dy);
                mul_b = MOW'(r_near);
            end
        endcase
    end

    // crossing test for the current edge: 0 <= num/den <= 1, t >= 0
    always_comb begin
        unique case (r_eix)
            E_LEFT: begin
                num = NW'(r_prod[M_A_TOP]) + NW'(r_prod[M_B_LFT]);
                tn  = DW'(r_rect.rect_left) - DW'(r_sx);
                td  = dx;
            end
            E_RIGHT: begin
                num = NW'(r_prod[M_A_TOP]) + NW'(r_prod[M_B_RGT]);
                tn  = DW'(r_rect.rect_right) - DW'(r_sx);
                td  = dx;
            end
            E_TOP: begin
                num = NW'(r_prod[M_A_TOP]) + NW'(r_prod[M_B_LFT]);
                tn  = DW'(r_rect.rect_top) - DW'(r_sy);
                td  = dy;
            end
            default: begin
                num = NW'(r_prod[M_A_BOT]) + NW'(r_prod[M_B_LFT]);
                tn  = DW'(r_rect.rect_bottom) - DW'(r_sy);
                td  = dy;
            end
        endcase
        den   = r_eix[1] ? r_prod[M_DEN_H] : r_prod[M_DEN_V];
        den_x = NW'(den);
        if (den == '0) begin
            u_ok = 1'b0;
        end else if (!den[SPW-1]) begin
            u_ok = !num[NW-1] && !(num > den_x);
        end else begin
            u_ok = !(num > 0) && !(num < den_x);
        end
        t_ok    = (td != '0) && !((tn != '0) && (tn[DW-1] != td[DW-1]));
        edge_go = u_ok && t_ok;
        div_num = CW'(tn[DW-1] ? -tn : tn);
        div_den = CW'(td[DW-1] ? -td : td);
    end

    // candidate from the divider replaces the minimum when strictly smaller
    assign q_better = (div_quot < DVW'(SENT)) && (div_quot < DVW'(r_near));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                if (mul_st.done && r_mix == M_B_RGT) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE: begin
                if (edge_go) begin
                    n_state = S_DIV;
                end else if (r_eix == E_BOTTOM) begin
                    n_state = fin_last ? (near_hit ? S_SMUL : S_EMIT) : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_st.done) begin
                    if (r_eix == E_BOTTOM) begin
                        n_state = fin_last ? (near_hit ? S_SMUL : S_EMIT) : S_IDLE;
                    end else begin
                        n_state = S_EDGE;
                    end
                end
            end
            S_SMUL: begin
                if (mul_st.done && r_mix == M_STP_Y) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        accept      = i_req_valid && o_req_ready;
        mul_start   = ((r_state == S_MUL) || (r_state == S_SMUL)) && !mul_st.busy;
        div_start   = (r_state == S_EDGE) && edge_go;
        emit_load   = (r_state == S_EMIT) && (!r_out_valid || i_rsp_ready);
        fin_last    = r_rect.last_rect;
        n_near      = r_near;
        if (emit_load) begin
            n_near = SENT;
        end else if ((r_state == S_DIV) && div_st.done && q_better) begin
            n_near = NPW'(div_quot);
        end
        near_hit = (n_near < SENT);
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_near      <= SENT;
            r_out_valid <= 1'b0;
            r_mix       <= M_DEN_V;
            r_eix       <= E_LEFT;
            r_sx        <= '0;
            r_sy        <= '0;
            r_ex        <= '0;
            r_ey        <= '0;
        end else begin
            r_state <= n_state;
            r_near  <= n_near;
            if (emit_load) begin
                r_out_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_valid <= 1'b0;
            end
            if (accept) begin
                r_mix <= M_DEN_V;
            end else if (mul_st.done) begin
                r_mix <= r_mix + 1'b1;
            end
            if (accept) begin
                r_eix <= E_LEFT;
            end else if (((r_state == S_EDGE) && !edge_go) ||
                         ((r_state == S_DIV) && div_st.done)) begin
                r_eix <= r_eix + 1'b1;
            end
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_START_X: r_sx <= i_cfg_data;
                    REG_START_Y: r_sy <= i_cfg_data;
                    REG_STOP_X:  r_ex <= i_cfg_data;
                    REG_STOP_Y:  r_ey <= i_cfg_data;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rect <= i_req;
        end
        if (mul_st.done) begin
            r_prod[r_mix] <= mul_prod;
        end
        if (emit_load) begin
            r_rsp.hit <= (r_near < SENT);
            if (r_near < SENT) begin
                r_rsp.stop_x <= stop_sat(r_prod[M_STP_X], r_sx);
                r_rsp.stop_y <= stop_sat(r_prod[M_STP_Y], r_sy);
            end else begin
                r_rsp.stop_x <= r_ex;
                r_rsp.stop_y <= r_ey;
            end
        end
    end

    assign o_rsp_valid = r_out_valid;
    assign o_rsp       = r_rsp;

    // checks
    `RREH_NEVER(a_near_cap, i_clk, i_rst_n, r_near > SENT)
    `RREH_NEVER(a_units_excl, i_clk, i_rst_n, mul_st.busy && div_st.busy)
    `RREH_NEXT(a_accept_mul, i_clk, i_rst_n, accept, r_state == S_MUL && r_mix == M_DEN_V)
    `RREH_NEXT(a_emit_valid, i_clk, i_rst_n, emit_load, o_rsp_valid && r_near == SENT)

endmodule

// ----- src/rreh_mul.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rreh_mul
// Bit-serial signed multiplier: one multiplier bit per cycle, shift-add on
// magnitudes, sign applied on the result.
// ============================================================================
module rreh_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic signed [rreh_pkg::MW:0]  i_a,
    input  logic signed [rreh_pkg::MW:0]  i_b,
    output rreh_pkg::t_ustat              o_st,
    output logic signed [rreh_pkg::PW:0]  o_prod
);
    import rreh_pkg::*;

    localparam int CNW = $clog2(MW + 1);

    logic            r_busy;
    logic [CNW-1:0]  r_cnt;
    logic [MW-1:0]   r_a;
    logic [PW-1:0]   r_p;
    logic            r_neg;

    logic [MW-1:0]   a_mag;
    logic [MW-1:0]   b_mag;
    logic [MW:0]     sum;
    logic [PW-1:0]   n_p;
    logic            last_step;

    // operand magnitudes
    assign a_mag = MW'(i_a[MW] ? -i_a : i_a);
    assign b_mag = MW'(i_b[MW] ? -i_b : i_b);

    // one shift-add step: low half holds remaining multiplier bits
    assign sum = {1'b0, r_p[PW-1:MW]} + {1'b0, (r_p[0] ? r_a : MW'(0))};
    assign n_p = {sum, r_p[MW-1:1]};

    assign last_step = (r_cnt == CNW'(MW));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (last_step) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= a_mag;
            r_p   <= {MW'(0), b_mag};
            r_neg <= i_a[MW] ^ i_b[MW];
        end else if (r_busy && !last_step) begin
            r_p <= n_p;
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_busy && last_step;
    assign o_prod    = r_neg ? -$signed({1'b0, r_p}) : $signed({1'b0, r_p});

endmodule

// ----- src/rreh_div.sv -----
`timescale 1ns / 1ps
// ============================================================================
// rreh_div
// Restoring radix-2 divider: floor((num << FRAC) / den), one quotient bit per
// cycle on unsigned magnitudes.
// ============================================================================
module rreh_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [rreh_pkg::CW-1:0]        i_num,
    input  logic [rreh_pkg::CW-1:0]        i_den,
    output rreh_pkg::t_ustat               o_st,
    output logic [rreh_pkg::DVW-1:0]       o_quot
);
    import rreh_pkg::*;

    localparam int CNW = $clog2(DVW + 1);

    logic            r_busy;
    logic [CNW-1:0]  r_cnt;
    logic [CW-1:0]   r_d;
    logic [CW-1:0]   r_rem;
    logic [DVW-1:0]  r_q;

    logic [CW:0]     trial;
    logic            ge;
    logic [CW-1:0]   n_rem;
    logic [DVW-1:0]  n_q;
    logic            last_step;

    // dividend bits leave at the top of r_q, quotient bits enter at the bottom
    assign trial = {r_rem, r_q[DVW-1]};
    assign ge    = (trial >= {1'b0, r_d});
    assign n_rem = ge ? CW'(trial - {1'b0, r_d}) : CW'(trial);
    assign n_q   = {r_q[DVW-2:0], ge};

    assign last_step = (r_cnt == CNW'(DVW));

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            if (last_step) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d   <= i_den;
            r_rem <= '0;
            r_q   <= {i_num, FRAC'(0)};
        end else if (r_busy && !last_step) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_st.busy = r_busy;
    assign o_st.done = r_busy && last_step;
    assign o_quot    = r_q;

endmodule

// ----- tb/tb_ray_rect_edge_nearest_hit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// tb_ray_rect_edge_nearest_hit
// Self-checking bench for the ray/rectangle edge nearest-hit block. A
// predictor computes the exact nearest edge crossing for each rectangle list,
// and a scoreboard checks every response field by field. Stimulus runs
// through several ray settings: directed corner cases first, then random
// rectangle lists placed along the ray, mixed with full-range noise. Both
// sides of the handshake stall in random bursts.
// ============================================================================
module tb_ray_rect_edge_nearest_hit;
    import rreh_pkg::*;

    localparam int  DRAIN_CYC   = 700;
    localparam longint CYC_LIMIT = 6000000;
    localparam longint ONE      = 64'sd65536;
    localparam longint PLIM     = 9000;

    logic         i_clk       = 1'b0;
    logic         i_rst_n     = 1'b0;
    logic         i_req_valid = 1'b0;
    logic         o_req_ready;
    t_req         i_req       = '0;
    logic         o_rsp_valid;
    logic         i_rsp_ready = 1'b0;
    t_rsp         o_rsp;
    logic         i_cfg_we    = 1'b0;
    logic [1:0]   i_cfg_idx   = '0;
    logic [CW-1:0] i_cfg_data = '0;

    bit     quiet = 1'b0;
    longint cycles = 0;
    int     rx_stall = 0;

    ray_rect_edge_nearest_hit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    // ------------------------------------------------------------------------
    // nearest-hit predictor and response store
    // ------------------------------------------------------------------------
    class hit_scoreboard;
        longint      ray_sx, ray_sy, ray_ex, ray_ey;
        int unsigned nearest;
        t_rsp        hit_q[$];
        int          errors;

        function new();
            ray_sx = 0; ray_sy = 0; ray_ex = 0; ray_ey = 0;
            nearest = PLIM * 65536;
            errors  = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [CW-1:0] data);
            longint v;
            v = longint'($signed(data));
            case (idx)
                REG_START_X: ray_sx = v;
                REG_START_Y: ray_sy = v;
                REG_STOP_X:  ray_ex = v;
                REG_STOP_Y:  ray_ey = v;
                default: ;
            endcase
        endfunction

        // one edge P + u*E against the ray
        function void cross_edge(longint px, longint py, longint ex, longint ey);
            longint dx, dy, n, d;
            longint unsigned un, ud, q;
            logic signed [127:0] wex, wey, wdx, wdy, wpy, wpx, den, num;
            dx = ray_ex - ray_sx;
            dy = ray_ey - ray_sy;
            wex = ex; wey = ey; wdx = dx; wdy = dy;
            wpy = py - ray_sy;
            wpx = ray_sx - px;
            den = wex * wdy - wey * wdx;
            num = wdx * wpy + wdy * wpx;
            if (den == 0) return;
            if (den > 0) begin
                if (num < 0 || num > den) return;
            end else begin
                if (num > 0 || num < den) return;
            end
            if (ex == 0) begin
                n = px - ray_sx; d = dx;
            end else begin
                n = py - ray_sy; d = dy;
            end
            if (d == 0) return;
            if (n != 0 && ((n < 0) != (d < 0))) return;
            un = (n < 0) ? -n : n;
            ud = (d < 0) ? -d : d;
            if (un / ud >= PLIM) return;
            q = (un << 16) / ud;
            if (q < nearest) nearest = int'(q);
        endfunction

        function logic [CW-1:0] stop_coord(longint s, longint e);
            logic signed [127:0] p, we, wn;
            longint v;
            we = e - s;
            wn = longint'(nearest);
            p  = we * wn;
            v  = longint'(p >>> 16) + s;
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            return v[CW-1:0];
        endfunction

        function void note_rect(t_req r);
            longint l, rt, t, b;
            t_rsp   o;
            l  = longint'(r.rect_left);
            rt = longint'(r.rect_right);
            t  = longint'(r.rect_top);
            b  = longint'(r.rect_bottom);
            cross_edge(l, t, 0, b - t);
            cross_edge(rt, t, 0, b - t);
            cross_edge(l, t, rt - l, 0);
            cross_edge(l, b, rt - l, 0);
            if (!r.last_rect) return;
            o.hit = (nearest < PLIM * 65536);
            if (o.hit) begin
                o.stop_x = stop_coord(ray_sx, ray_ex);
                o.stop_y = stop_coord(ray_sy, ray_ey);
            end else begin
                o.stop_x = ray_ex[CW-1:0];
                o.stop_y = ray_ey[CW-1:0];
            end
            hit_q = {hit_q, o};
            nearest = PLIM * 65536;
        endfunction

        task report(string what);
            errors++;
            $display("MISMATCH %s at cycle %0d", what, cycles);
        endtask

        task check_rsp(t_rsp got);
            t_rsp exp_r;
            if (hit_q.size() == 0) begin
                report("response with nothing pending");
                return;
            end
            exp_r = hit_q.pop_front();
            if (got.hit !== exp_r.hit)
                report($sformatf("hit got %0b want %0b", got.hit, exp_r.hit));
            if (got.stop_x !== exp_r.stop_x)
                report($sformatf("stop_x got %h want %h", got.stop_x, exp_r.stop_x));
            if (got.stop_y !== exp_r.stop_y)
                report($sformatf("stop_y got %h want %h", got.stop_y, exp_r.stop_y));
        endtask
    endclass

    hit_scoreboard sb = new();

    // clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("ray_rect_edge_nearest_hit regression: fail");
            $finish;
        end
    end

    // response side: check and stall in bursts
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid && i_rsp_ready)
            sb.check_rsp(o_rsp);
        if (quiet) begin
            i_rsp_ready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            i_rsp_ready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            rx_stall <= $urandom_range(1, 13) - 1;
            i_rsp_ready <= 1'b0;
        end else begin
            i_rsp_ready <= 1'b1;
        end
    end

    // one register write; the caller drops the write enable after the last one
    task write_reg(logic [1:0] idx, logic [CW-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.set_reg(idx, data);
    endtask

    task set_ray(longint sx, longint sy, longint ex, longint ey);
        write_reg(REG_START_X, sx[CW-1:0]);
        write_reg(REG_START_Y, sy[CW-1:0]);
        write_reg(REG_STOP_X, ex[CW-1:0]);
        write_reg(REG_STOP_Y, ey[CW-1:0]);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // one request; valid stays high into the next request when no gap
    task send_rect(t_req r);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 13);
        if (gap > 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_req       <= r;
        i_req_valid <= 1'b1;
        do @(posedge i_clk); while (!o_req_ready);
        sb.note_rect(r);
    endtask

    task send_box(longint l, longint r, longint t, longint b, bit last);
        t_req q;
        q.rect_left   = l[CW-1:0];
        q.rect_right  = r[CW-1:0];
        q.rect_top    = t[CW-1:0];
        q.rect_bottom = b[CW-1:0];
        q.last_rect   = last;
        send_rect(q);
    endtask

    // wait out all pending responses and any rectangle still in flight
    task settle();
        @(posedge i_clk);
        i_req_valid <= 1'b0;
        while (sb.hit_q.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYC) @(posedge i_clk);
    endtask

    function longint small_coord(int span);
        return longint'($urandom_range(0, 2 * span * 65536)) - longint'(span) * ONE;
    endfunction

    // random rectangle lists, mostly placed along the ray
    task random_phase(int count);
        longint sx, sy, ex, ey, cx, cy, hw, hh, f;
        t_req   q;
        int     left;
        sx = small_coord(200); sy = small_coord(200);
        ex = small_coord(200); ey = small_coord(200);
        if ($urandom_range(0, 5) == 0) ey = sy;
        if ($urandom_range(0, 5) == 0) ex = sx;
        set_ray(sx, sy, ex, ey);
        left = $urandom_range(1, 4);
        for (int k = 0; k < count; k++) begin
            left--;
            if ($urandom_range(0, 9) == 0) begin
                q = {$urandom, $urandom, $urandom, $urandom, 1'b0};
                q.last_rect = (left <= 0);
                send_rect(q);
            end else begin
                f  = $urandom_range(0, 600);
                cx = sx + (((ex - sx) * f) >>> 8) + small_coord(4);
                cy = sy + (((ey - sy) * f) >>> 8) + small_coord(4);
                hw = longint'($urandom_range(0, 20 * 65536));
                hh = longint'($urandom_range(0, 20 * 65536));
                if ($urandom_range(0, 15) == 0) send_box(cx + hw, cx - hw, cy - hh, cy + hh,
                                                         left <= 0);
                else send_box(cx - hw, cx + hw, cy - hh, cy + hh, left <= 0);
            end
            if (left <= 0) left = $urandom_range(1, 4);
        end
        // close the list so the phase ends idle
        send_box(sx, sx, sy, sy, 1'b1);
        settle();
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // zero-length ray at reset values: never a hit
        send_box(-ONE, ONE, -ONE, ONE, 1'b1);
        send_box(64'sh80000000 - 64'sh100000000, 64'sh7FFFFFFF,
                 64'sh80000000 - 64'sh100000000, 64'sh7FFFFFFF, 1'b1);
        settle();

        // unit ray along x; far crossing at and just under the sentinel
        set_ray(0, 0, ONE, 0);
        send_box(9000 * ONE, 9001 * ONE, -ONE, ONE, 1'b1);
        send_box(8999 * ONE, 9001 * ONE, -ONE, ONE, 1'b1);
        send_box(2 * ONE, 3 * ONE, -ONE, ONE, 1'b0);
        send_box(ONE / 2, ONE, -ONE, ONE, 1'b1);
        // parallel edges, degenerate rect, behind the ray
        send_box(ONE, 2 * ONE, 0, 0, 1'b1);
        send_box(ONE, ONE, ONE, ONE, 1'b1);
        send_box(-3 * ONE, -2 * ONE, -ONE, ONE, 1'b1);
        // unordered rect, edge endpoints exactly on the ray
        send_box(3 * ONE, ONE, ONE, -ONE, 1'b1);
        send_box(ONE, 2 * ONE, 0, ONE, 1'b1);
        settle();

        // extreme registers and fields
        set_ray(-64'sd2147483648, -64'sd2147483648, 64'sd2147483647, 64'sd2147483647);
        send_box(-64'sd2147483648, 64'sd2147483647, -64'sd2147483648, 64'sd2147483647,
                 1'b1);
        send_box(0, 1, 0, 1, 1'b1);
        send_box(64'sd2147483647, -64'sd2147483648, 64'sd2147483647, -64'sd2147483648,
                 1'b1);
        send_box(-ONE, ONE, -ONE, ONE, 1'b0);
        send_box(64'sd1000000, 64'sd2000000, -64'sd5000000, 64'sd5000000, 1'b1);
        settle();

        // vertical ray, odd fractional crossing
        set_ray(ONE / 3, 64'sd2147483647, ONE / 3, -64'sd2147483648);
        send_box(-ONE, ONE, -7 * ONE, 5 * ONE, 1'b1);
        send_box(-ONE, ONE, 3, 7, 1'b1);
        settle();

        for (int p = 0; p < 11; p++) random_phase(140);
        quiet = 1'b1;
        random_phase(120);

        if (sb.errors == 0) begin
            $display("ray_rect_edge_nearest_hit regression: pass");
        end else begin
            $display("ray_rect_edge_nearest_hit regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+src
src/rreh_pkg.sv
src/rreh_mul.sv
src/rreh_div.sv
src/ray_rect_edge_nearest_hit.sv
tb/tb_ray_rect_edge_nearest_hit.sv
